// File: design/rar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg
// Widths and opcodes shared by the rational arithmetic reduce block.
// ----------------------------------------------------------------------------
package rar_pkg;

  // operand width and derived internal widths
  localparam int OPW = 16;          // width of each input numerator / denominator
  localparam int RW  = OPW + 1;     // reduced operand part (negating -2^(OPW-1))
  localparam int NW  = 33;          // result numerator, signed
  localparam int DW  = 31;          // result denominator, unsigned
  localparam int MW  = NW - 1;      // magnitude width for gcd and divider
  localparam int AW  = NW + 1;      // shared add / subtract unit width
  localparam int PW  = 2 * RW;      // full product width
  localparam int KW  = $clog2(MW);  // shared power of two count and divider count

  // opcodes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

endpackage

// File: design/rational_arith_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and returns the
// result reduced to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries an opcode and the two fractions a_num/a_den and
//   b_num/b_den. A request is taken when in_valid is high and in_stall is low.
//   in_stall stays high while a request is being worked on.
//   Each operand is reduced, the operation is done by cross multiplication and
//   the raw result is reduced again. A zero denominator leaves a fraction as is.
//   The result channel gives res_num (signed) and res_den (zero marks an
//   undefined, unreduced result).
// Sequencing:
//   One request at a time. Each of the three reductions runs a binary gcd
//   loop on one shared add / subtract unit (one shift, subtract or swap a
//   cycle), then two restoring divisions on the same unit. A zero
//   denominator skips its reduction. The cross products run through S_MUL0
//   to S_MUL2, plus S_MUL3 for add and subtract, on one 17 x 17 multiplier.
// Reset and stall:
//   rst_n is synchronous and active low; it drops any request in flight and
//   clears the output valid. A stalled result holds in the output register;
//   the next request is accepted meanwhile and waits at its end for the
//   output register to free up.
// ----------------------------------------------------------------------------
module rational_arith_reduce (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic signed [rar_pkg::OPW-1:0]    in_a_num,
  input  logic signed [rar_pkg::OPW-1:0]    in_a_den,
  input  logic signed [rar_pkg::OPW-1:0]    in_b_num,
  input  logic signed [rar_pkg::OPW-1:0]    in_b_den,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rar_pkg::NW-1:0]     out_res_num,
  output logic [rar_pkg::DW-1:0]            out_res_den
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_NEG_NUM, S_NEG_DEN, S_MAG, S_GCD, S_DIV_LOAD, S_DIV_RUN,
    S_SIGN, S_STORE, S_MUL0, S_MUL1, S_MUL2, S_MUL3, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;

  state_t                 state_r;
  phase_t                 phase_r;
  logic [1:0]             opcode_r;
  logic signed [RW-1:0]   an_r, ad_r, bn_r, bd_r;
  logic signed [NW-1:0]   num_r, den_r;
  logic                   neg_r;
  logic [MW-1:0]          x_r, y_r;
  logic [KW-1:0]          k_r;
  logic [MW-1:0]          rem_r, quo_r, dvs_r;
  logic [KW-1:0]          cnt_r;
  logic                   div_den_r;
  logic signed [PW-1:0]   prod_r;
  logic                   out_valid_r;
  logic signed [NW-1:0]   out_res_num_r;
  logic [DW-1:0]          out_res_den_r;

  logic [AW-1:0]          alu_a, alu_b, alu_y;
  logic                   alu_sub;
  logic signed [RW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  logic                   div_ge;
  logic [MW-1:0]          rem_step, quo_step;
  logic                   last_bit;

  // shared add / subtract unit operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      S_NEG_NUM: alu_b = {num_r[NW-1], num_r};
      S_NEG_DEN: alu_b = {den_r[NW-1], den_r};
      S_MAG: begin
        alu_b   = {num_r[NW-1], num_r};
        alu_sub = num_r[NW-1];
      end
      S_GCD: begin
        alu_a = {2'b00, x_r};
        alu_b = {2'b00, y_r};
      end
      S_DIV_RUN: begin
        alu_a = {1'b0, rem_r, quo_r[MW-1]};
        alu_b = {2'b00, dvs_r};
      end
      S_SIGN: begin
        alu_b   = {num_r[NW-1], num_r};
        alu_sub = neg_r;
      end
      S_MUL3: begin
        alu_a   = {num_r[NW-1], num_r};
        alu_b   = AW'(prod_r);
        alu_sub = (opcode_r == OP_SUB);
      end
      default: ;
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // restoring divider step
  assign div_ge   = !alu_y[AW-1];
  assign rem_step = div_ge ? alu_y[MW-1:0] : {rem_r[MW-2:0], quo_r[MW-1]};
  assign quo_step = {quo_r[MW-2:0], div_ge};
  assign last_bit = (cnt_r == KW'(MW - 1));

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        mul_b = (opcode_r == OP_MUL) ? bn_r : bd_r;
      end
      S_MUL1: begin
        mul_a = ad_r;
        mul_b = (opcode_r == OP_DIV) ? bn_r : bd_r;
      end
      S_MUL2: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_A;
      out_valid_r <= 1'b0;
    end else begin
      // output register loads from the sequencer or drains
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            opcode_r <= in_opcode;
            num_r    <= {{(NW-OPW){in_a_num[OPW-1]}}, in_a_num};
            den_r    <= {{(NW-OPW){in_a_den[OPW-1]}}, in_a_den};
            bn_r     <= {{(RW-OPW){in_b_num[OPW-1]}}, in_b_num};
            bd_r     <= {{(RW-OPW){in_b_den[OPW-1]}}, in_b_den};
            phase_r  <= PH_A;
            state_r  <= S_CHK;
          end
        end
        // zero denominator stays unreduced, negative one is flipped
        S_CHK: begin
          if (den_r == '0) begin
            state_r <= S_STORE;
          end else if (den_r[NW-1]) begin
            state_r <= S_NEG_NUM;
          end else begin
            state_r <= S_MAG;
          end
        end
        S_NEG_NUM: begin
          num_r   <= alu_y[NW-1:0];
          state_r <= S_NEG_DEN;
        end
        S_NEG_DEN: begin
          den_r   <= alu_y[NW-1:0];
          state_r <= S_MAG;
        end
        // keep the sign, work on magnitudes
        S_MAG: begin
          neg_r   <= num_r[NW-1];
          num_r   <= alu_y[NW-1:0];
          x_r     <= alu_y[MW-1:0];
          y_r     <= den_r[MW-1:0];
          k_r     <= '0;
          state_r <= S_GCD;
        end
        // binary gcd, one shift, subtract or swap per cycle
        S_GCD: begin
          if (x_r == '0) begin
            dvs_r     <= y_r << k_r;
            div_den_r <= 1'b0;
            state_r   <= S_DIV_LOAD;
          end else if (y_r == '0) begin
            dvs_r     <= x_r << k_r;
            div_den_r <= 1'b0;
            state_r   <= S_DIV_LOAD;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (!alu_y[AW-1]) begin
            x_r <= alu_y[MW:1];
          end else begin
            x_r <= y_r;
            y_r <= x_r;
          end
        end
        // exact division of numerator, then denominator, by the gcd
        S_DIV_LOAD: begin
          rem_r   <= '0;
          quo_r   <= div_den_r ? den_r[MW-1:0] : num_r[MW-1:0];
          cnt_r   <= '0;
          state_r <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          rem_r <= rem_step;
          quo_r <= quo_step;
          cnt_r <= cnt_r + 1'b1;
          if (last_bit) begin
            if (!div_den_r) begin
              num_r     <= {1'b0, quo_step};
              div_den_r <= 1'b1;
              state_r   <= S_DIV_LOAD;
            end else begin
              den_r   <= {1'b0, quo_step};
              state_r <= S_SIGN;
            end
          end
        end
        S_SIGN: begin
          num_r   <= alu_y[NW-1:0];
          state_r <= S_STORE;
        end
        // hand the reduced fraction on
        S_STORE: begin
          case (phase_r)
            PH_A: begin
              an_r    <= num_r[RW-1:0];
              ad_r    <= den_r[RW-1:0];
              num_r   <= {{(NW-RW){bn_r[RW-1]}}, bn_r};
              den_r   <= {{(NW-RW){bd_r[RW-1]}}, bd_r};
              phase_r <= PH_B;
              state_r <= S_CHK;
            end
            PH_B: begin
              bn_r    <= num_r[RW-1:0];
              bd_r    <= den_r[RW-1:0];
              state_r <= S_MUL0;
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        // cross products
        S_MUL0: begin
          prod_r  <= mul_p;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          num_r   <= prod_r[NW-1:0];
          prod_r  <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          den_r   <= prod_r[NW-1:0];
          phase_r <= PH_R;
          if (opcode_r inside {OP_ADD, OP_SUB}) begin
            prod_r  <= mul_p;
            state_r <= S_MUL3;
          end else begin
            state_r <= S_CHK;
          end
        end
        S_MUL3: begin
          num_r   <= alu_y[NW-1:0];
          state_r <= S_CHK;
        end
        // load the output register once it is free
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_res_num_r <= num_r;
            out_res_den_r <= den_r[DW-1:0];
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = out_res_num_r;
  assign out_res_den = out_res_den_r;

`ifndef SYNTHESIS
  // divisor is the gcd of a nonzero denominator
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_RUN) |-> (dvs_r != '0))
    else $error("divider running with zero divisor");

  // gcd operands never both zero
  a_gcd_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> (x_r != '0 || y_r != '0))
    else $error("gcd operands both zero");

  // division by the gcd is exact
  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_RUN && last_bit) |=> (rem_r == '0))
    else $error("division by gcd left a remainder");

  // result denominator is never negative
  a_den_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> !den_r[NW-1])
    else $error("negative result denominator");
`endif

endmodule
